>>> design/rkx_pkg.sv
// rkx_pkg: shared types, constants and key byte selection for the
// rotating-key xor stream block. No dependencies.
package rkx_pkg;

	localparam logic [63:0] KEY_INIT   = 64'h7CBD_BD9B_F3E4_C1B4;
	localparam int          PADDR_W    = 3;
	localparam int          PDATA_W    = 32;
	localparam int          LOAD_W     = 16;
	localparam logic [2:0]  CNT_FIRST  = 3'd3;
	localparam logic [2:0]  CNT_CODED  = 3'd4;
	localparam logic [7:0]  POS_OFFSET = 8'd3;
	localparam logic [2:0]  SEL_FLIP   = 3'd2;
	localparam logic        REG_LOAD_ADDRESS = 1'b0;

	// one result transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} rkx_result_t;

	// stream state seen from outside the core
	typedef struct packed {
		logic [2:0] byte_count;
		logic [7:0] page_position;
	} rkx_status_t;

	// key byte j, counted from the most significant end
	function automatic logic [7:0] key_byte(input logic [63:0] key, input logic [2:0] j);
		logic [2:0] sel;
		sel = 3'd7 - j;
		return key[{sel, 3'b000} +: 8];
	endfunction

endpackage

>>> design/rkx_cfg.sv
// rkx_cfg: apb-style register port holding load_address.
// Depends on rkx_pkg.
module rkx_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rkx_pkg::PADDR_W-1:0] paddr,
	input  logic [rkx_pkg::PDATA_W-1:0] pwdata,
	output logic [rkx_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [rkx_pkg::LOAD_W-1:0]  load_address
);
	import rkx_pkg::*;

	logic [LOAD_W-1:0] load_address_q;
	logic              reg_sel;

	// word decode on the register index bit
	assign reg_sel = (paddr[2] == REG_LOAD_ADDRESS);
	assign pready  = 1'b1;

	// register write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_address_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			load_address_q <= pwdata[LOAD_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(PDATA_W-LOAD_W){1'b0}}, load_address_q};
		end
	end

	assign load_address = load_address_q;
endmodule

>>> design/rkx_core.sv
// rkx_core: stream state (key, running sum, page position, byte count)
// and the combinational coding step. Depends on rkx_pkg.
module rkx_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	input  logic [rkx_pkg::LOAD_W-1:0] load_address,
	output rkx_pkg::rkx_result_t       result,
	output rkx_pkg::rkx_status_t       status
);
	import rkx_pkg::*;

	logic [63:0] key_q;
	logic [7:0]  sum_q;
	logic [7:0]  pos_q;
	logic [2:0]  cnt_q;

	logic        coded;
	logic        first;
	logic [7:0]  pos_eff;
	logic [63:0] key_eff;
	logic [7:0]  a_byte;
	logic [7:0]  b_byte;
	logic [7:0]  sum_new;

	// coding step
	always_comb begin
		coded   = (cnt_q >= CNT_FIRST);
		first   = (cnt_q == CNT_FIRST);
		pos_eff = first ? (load_address[7:0] + POS_OFFSET) : pos_q;
		key_eff = (first || pos_eff == 8'd0) ? {key_q[62:0], key_q[63]} : key_q;
		a_byte  = key_byte(key_eff, pos_eff[2:0] ^ SEL_FLIP);
		b_byte  = key_byte(key_eff, a_byte[2:0]);
		sum_new = a_byte + sum_q + b_byte;
	end

	assign result.out_byte = coded ? (data_byte ^ sum_new) : data_byte;
	assign result.out_last = last_byte;

	// state update per accepted transfer; last byte returns to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_INIT;
			sum_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				key_q <= KEY_INIT;
				sum_q <= '0;
				pos_q <= '0;
				cnt_q <= '0;
			end else if (coded) begin
				key_q <= key_eff;
				sum_q <= sum_new;
				pos_q <= pos_eff + 8'd1;
				cnt_q <= CNT_CODED;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	assign status.byte_count    = cnt_q;
	assign status.page_position = pos_q;
endmodule

>>> design/rotating_key_xor_stream_decryptor.sv
// rotating_key_xor_stream_decryptor: top level, register port, core and
// result register. Depends on rkx_pkg, rkx_cfg, rkx_core.
//
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     data_byte, last_byte
// output    out        out_valid / out_ready   out_byte, out_last
// config    in         psel/penable/pwrite     paddr, pwdata -> prdata
//
// One byte per cycle while the result is not stalled: the coding step is one
// rotate, two key byte selects and an 8-bit three-input add between the state
// and result register. The result is valid in the cycle after the transfer.
// Reset clears the stream state and empties the result register.
// A stalled result holds; a new byte is taken in the cycle the result leaves.
module rotating_key_xor_stream_decryptor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        out_last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rkx_pkg::PADDR_W-1:0] paddr,
	input  logic [rkx_pkg::PDATA_W-1:0] pwdata,
	output logic [rkx_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import rkx_pkg::*;

	logic              in_xfer;
	logic [LOAD_W-1:0] load_address;
	rkx_result_t       result;
	rkx_status_t       status;
	rkx_result_t       result_q;
	logic              out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	rkx_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.load_address (load_address)
	);

	rkx_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_xfer),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.load_address (load_address),
		.result       (result),
		.status       (status)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = result_q.out_byte;
	assign out_last  = result_q.out_last;

	// last byte returns the stream state to reset
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last_byte |=> status.byte_count == 3'd0 && status.page_position == 8'd0)
		else $error("stream state not cleared after last byte");

	// byte count saturates at the coded value
	assert property (@(posedge clk) disable iff (!arst_n)
		status.byte_count <= CNT_CODED)
		else $error("byte count beyond saturation");

	// an accepted byte is shown as a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_valid)
		else $error("result missing after input transfer");

	// an empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");
endmodule

>>> sim/tb_rotating_key_xor_stream_decryptor.sv
`timescale 1ns / 1ps
// tb_rotating_key_xor_stream_decryptor: self-checking testbench for the rotating-key xor
// stream block, with its own byte-level predictor and random stalls on both channels.
// Depends on rkx_pkg and rotating_key_xor_stream_decryptor.
module tb_rotating_key_xor_stream_decryptor;
	import rkx_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_LOAD_ADDRESS = PADDR_W'({REG_LOAD_ADDRESS, 2'b00});
	localparam int HOLD_OFF_CYCLES = 200;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = 8'd0;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          out_byte;
	logic                out_last;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// predicted stream state and register copy
	logic [63:0]         pred_key;
	logic [7:0]          pred_sum;
	logic [7:0]          pred_pos;
	logic [2:0]          pred_count;
	logic [LOAD_W-1:0]   load_address_cfg;

	rkx_result_t         expected_q[$];
	int                  mismatch_count = 0;
	int                  n_sent = 0;
	bit                  tx_idle = 1'b1;
	bit                  rx_idle = 1'b1;
	int                  hold_cycles_req = 0;

	rotating_key_xor_stream_decryptor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// byte j of the key, counted from the most significant end
	function automatic logic [7:0] key_sel(input logic [63:0] key, input logic [2:0] j);
		return 8'(key >> (8 * (7 - int'(j))));
	endfunction

	function automatic void clear_stream();
		pred_key   = KEY_INIT;
		pred_sum   = 8'd0;
		pred_pos   = 8'd0;
		pred_count = 3'd0;
	endfunction

	// expected result for one accepted byte, advancing the predicted state
	function automatic rkx_result_t decode_byte(input logic [7:0] d, input logic l);
		rkx_result_t r;
		logic        first;
		logic [7:0]  a;
		r.out_byte = d;
		r.out_last = l;
		if (pred_count < CNT_FIRST) begin
			pred_count = pred_count + 3'd1;
		end else begin
			first = (pred_count == CNT_FIRST);
			if (first)
				pred_pos = load_address_cfg[7:0] + POS_OFFSET;
			// a single rotation even when both conditions hold
			if (first || pred_pos == 8'd0)
				pred_key = {pred_key[62:0], pred_key[63]};
			a = key_sel(pred_key, pred_pos[2:0] ^ SEL_FLIP);
			pred_sum = a + pred_sum + key_sel(pred_key, a[2:0]);
			r.out_byte = d ^ pred_sum;
			pred_pos = pred_pos + 8'd1;
			pred_count = CNT_CODED;
		end
		if (l)
			clear_stream();
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [LOAD_W-1:0] pick_load_address();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFD;
			3: return {8'($urandom_range(0, 255)), 8'hFC};
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch %s at %0t: got %h, expected %h", what, $time, got, want);
		mismatch_count++;
	endtask

	// offer one byte and hold it until the transfer
	task automatic offer_byte(input logic [7:0] d, input logic l);
		in_valid  <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(decode_byte(d, l));
		n_sent++;
	endtask

	task automatic sender_pause();
		int n;
		if (tx_idle && $urandom_range(0, 99) < 30) begin
			n = gap_length();
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_stream(input int len);
		for (int i = 0; i < len; i++) begin
			offer_byte(8'($urandom_range(0, 255)), i == len - 1);
			sender_pause();
		end
	endtask

	// drain every outstanding result, then allow for the result register
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// register write followed by a read back
	task automatic write_load_address(input logic [LOAD_W-1:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_LOAD_ADDRESS;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		load_address_cfg = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(value)) begin
			report_mismatch("load_address read back, low byte", prdata[7:0], value[7:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// first stream under the reset value of the register, data extremes
	task automatic test_reset_value_stream();
		offer_byte(8'h00, 1'b0);
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'hA5, 1'b0);
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'h00, 1'b1);
	endtask

	// streams that end inside the plain header
	task automatic test_short_streams();
		offer_byte(8'h5A, 1'b1);
		offer_byte(8'h12, 1'b0);
		offer_byte(8'h34, 1'b1);
		offer_byte(8'hC3, 1'b0);
		sender_pause();
		offer_byte(8'h3C, 1'b0);
		offer_byte(8'h99, 1'b1);
	endtask

	// start position zero: first coded byte and page wrap coincide
	task automatic test_start_on_page_zero();
		write_load_address(16'hFFFD);
		offer_byte(8'h80, 1'b0);
		offer_byte(8'h01, 1'b0);
		offer_byte(8'h7F, 1'b0);
		offer_byte(8'hFE, 1'b0);
		offer_byte(8'h55, 1'b1);
	endtask

	// page wrap on the second coded byte, register changed mid-stream
	task automatic test_config_mid_stream();
		write_load_address(16'h00FC);
		offer_byte(8'h11, 1'b0);
		offer_byte(8'h22, 1'b0);
		offer_byte(8'h33, 1'b0);
		offer_byte(8'h44, 1'b0);
		offer_byte(8'h55, 1'b0);
		write_load_address(16'hFFFF);
		offer_byte(8'h66, 1'b1);
		send_stream(5);
	endtask

	// well-formed streams of random length and content
	task automatic test_random_streams(input int budget);
		int first_sent;
		int len;
		int r;
		first_sent = n_sent;
		while (n_sent - first_sent < budget) begin
			if ($urandom_range(0, 1))
				write_load_address(pick_load_address());
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 15)
				len = $urandom_range(1, 3);
			else if (r < 85)
				len = $urandom_range(4, 40);
			else
				len = $urandom_range(41, 300);
			send_stream(len);
		end
	endtask

	// one stream crossing a page wrap, no idling on either side
	task automatic test_long_stream();
		write_load_address(pick_load_address());
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_stream(300);
		wait_idle();
	endtask

	// last flag at random, so stream boundaries fall anywhere
	task automatic test_random_last(input int count);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_load_address(pick_load_address());
		for (int i = 0; i < count; i++) begin
			offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			sender_pause();
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		wait_idle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_cycles_req = HOLD_OFF_CYCLES;
		repeat (2) @(posedge clk);
		send_stream(40);
		wait_idle();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// result checking and receiver stalls
	initial begin
		rkx_result_t want;
		int          stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result transfer with nothing expected", out_byte, 8'h00);
				end else begin
					want = expected_q.pop_front();
					if (out_byte !== want.out_byte)
						report_mismatch("out_byte", out_byte, want.out_byte);
					if (out_last !== want.out_last)
						report_mismatch("out_last", 8'(out_last), 8'(want.out_last));
				end
			end
			if (hold_cycles_req != 0) begin
				stall_left = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 99) < 25) begin
				stall_left = gap_length() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// test sequence
	initial begin
		clear_stream();
		load_address_cfg = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_value_stream();
		test_short_streams();
		test_start_on_page_zero();
		test_config_mid_stream();
		test_output_backpressure();
		test_long_stream();
		test_random_streams(800);
		test_random_last(150);
		write_load_address(16'hFFFF);
		write_load_address(16'h0000);
		send_stream(12);
		wait_idle();
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/rkx_pkg.sv
design/rkx_cfg.sv
design/rkx_core.sv
design/rotating_key_xor_stream_decryptor.sv
sim/tb_rotating_key_xor_stream_decryptor.sv
